// ----- src/cck_pkg.sv -----
// ----------------------------------------------------------------------------
// cck_pkg
// Shared types, constants and ChaCha round functions for the keystream XOR.
// ----------------------------------------------------------------------------
package cck_pkg;

  localparam int NumRegs    = 8;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  // Register indexes
  localparam logic [2:0] REG_CONST01  = 3'd0;
  localparam logic [2:0] REG_CONST23  = 3'd1;
  localparam logic [2:0] REG_KEY01    = 3'd2;
  localparam logic [2:0] REG_KEY23    = 3'd3;
  localparam logic [2:0] REG_KEY45    = 3'd4;
  localparam logic [2:0] REG_KEY67    = 3'd5;
  localparam logic [2:0] REG_COUNTER  = 3'd6;
  localparam logic [2:0] REG_NONCE    = 3'd7;

  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_LAST  = 3'd7;

  typedef logic [15:0][31:0]        state_t;
  typedef logic [NumRegs-1:0][63:0] regs_t;

  // One queued item: data word, position within the block, block counter
  typedef struct packed {
    logic [63:0] data;
    logic [2:0]  pos;
    logic [63:0] count;
  } entry_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // Quarter round, returns {a, b, c, d}
  function automatic logic [127:0] quarter(input logic [31:0] a_i, input logic [31:0] b_i,
                                           input logic [31:0] c_i, input logic [31:0] d_i);
    logic [31:0] a, b, c, d;
    a = a_i; b = b_i; c = c_i; d = d_i;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    quarter = {a, b, c, d};
  endfunction

  // Column round followed by diagonal round
  function automatic state_t dround(input state_t s);
    state_t x;
    x = s;
    {x[0], x[4], x[8],  x[12]} = quarter(x[0], x[4], x[8],  x[12]);
    {x[1], x[5], x[9],  x[13]} = quarter(x[1], x[5], x[9],  x[13]);
    {x[2], x[6], x[10], x[14]} = quarter(x[2], x[6], x[10], x[14]);
    {x[3], x[7], x[11], x[15]} = quarter(x[3], x[7], x[11], x[15]);
    {x[0], x[5], x[10], x[15]} = quarter(x[0], x[5], x[10], x[15]);
    {x[1], x[6], x[11], x[12]} = quarter(x[1], x[6], x[11], x[12]);
    {x[2], x[7], x[8],  x[13]} = quarter(x[2], x[7], x[8],  x[13]);
    {x[3], x[4], x[9],  x[14]} = quarter(x[3], x[4], x[9],  x[14]);
    dround = x;
  endfunction

endpackage

// ----- src/cck_front.sv -----
// ----------------------------------------------------------------------------
// cck_front
// Accepts items, tracks word position and block counter, tags each item.
// ----------------------------------------------------------------------------
module cck_front import cck_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_in,
  input  logic        in_restart,
  input  logic [63:0] start_count,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  logic [2:0]  pos_r, pos_nxt, pos_eff;
  logic [63:0] cnt_r, cnt_nxt, cnt_eff;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Restart reloads the configured counter before this item
  assign pos_eff = in_restart ? POS_FIRST : pos_r;
  assign cnt_eff = in_restart ? start_count : cnt_r;

  assign q_entry = '{data: in_data_in, pos: pos_eff, count: cnt_eff};

  always_comb begin
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    if (q_push) begin
      pos_nxt = pos_eff + 3'd1;
      cnt_nxt = (pos_eff == POS_LAST) ? cnt_eff + 64'd1 : cnt_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_FIRST;
      cnt_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/cck_queue.sv -----
// ----------------------------------------------------------------------------
// cck_queue
// Small FIFO of tagged items between the front and the keystream back end.
// ----------------------------------------------------------------------------
module cck_queue import cck_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  entry_t                  mem_r [QueueDepth];
  logic [QueuePtrW-1:0]    wr_r, rd_r;
  logic [QueuePtrW:0]      fill_r;

  assign full  = (fill_r == (QueuePtrW+1)'(QueueDepth));
  assign empty = (fill_r == '0);
  assign head  = mem_r[rd_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      fill_r <= fill_r + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
  end

endmodule

// ----- src/cck_back.sv -----
// ----------------------------------------------------------------------------
// cck_back
// Builds keystream blocks one double round per cycle and XORs queued words.
// ----------------------------------------------------------------------------
module cck_back import cck_pkg::*; #(
  parameter int ROUNDS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  regs_t       cfg,
  input  logic        q_empty,
  input  entry_t      q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data_out
);

  localparam int Pairs = (ROUNDS + 1) / 2;
  localparam int CntW  = $clog2(Pairs + 1);

  typedef enum logic [2:0] {
    B_SERVE = 3'b001,
    B_ROUND = 3'b010,
    B_FIN   = 3'b100
  } bstate_t;

  bstate_t       st_r;
  state_t        init_r, x_r, ks_r, init_w;
  logic [CntW-1:0] rcnt_r;
  logic          gen_done_r;
  logic          out_valid_r;
  logic [63:0]   out_data_r;
  logic          out_free, can_serve, need_gen;
  logic [3:0]    lo_idx, hi_idx;

  assign out_free  = !out_valid_r || !out_stall;
  assign can_serve = (st_r == B_SERVE) && !q_empty && out_free;
  assign need_gen  = (q_head.pos == POS_FIRST) && !gen_done_r;
  assign q_pop     = can_serve && !need_gen;

  assign lo_idx = {q_head.pos, 1'b0};
  assign hi_idx = {q_head.pos, 1'b1};

  // Initial state from the registers and the item's block counter
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      init_w[2*i]   = cfg[i][31:0];
      init_w[2*i+1] = cfg[i][63:32];
    end
    init_w[12] = q_head.count[31:0];
    init_w[13] = q_head.count[63:32];
    init_w[14] = cfg[REG_NONCE][31:0];
    init_w[15] = cfg[REG_NONCE][63:32];
  end

  // Block generation sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= B_SERVE;
      gen_done_r <= 1'b0;
      rcnt_r     <= '0;
    end else begin
      unique case (st_r)
        B_SERVE: begin
          if (can_serve && need_gen) begin
            st_r   <= B_ROUND;
            rcnt_r <= CntW'(Pairs - 1);
          end else if (q_pop) begin
            gen_done_r <= 1'b0;
          end
        end
        B_ROUND: begin
          if (rcnt_r == '0) st_r <= B_FIN;
          else rcnt_r <= rcnt_r - 1'b1;
        end
        B_FIN: begin
          st_r       <= B_SERVE;
          gen_done_r <= 1'b1;
        end
        default: st_r <= B_SERVE;
      endcase
    end
  end

  // Round datapath
  always_ff @(posedge clk) begin
    if (can_serve && need_gen) begin
      init_r <= init_w;
      x_r    <= init_w;
    end else if (st_r == B_ROUND) begin
      x_r <= dround(x_r);
    end
    if (st_r == B_FIN) begin
      for (int i = 0; i < 16; i++) ks_r[i] <= x_r[i] + init_r[i];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= q_pop;
    end
    if (q_pop) begin
      out_data_r <= q_head.data ^ {ks_r[hi_idx], ks_r[lo_idx]};
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

endmodule

// ----- src/chacha_keystream_xor.sv -----
// ----------------------------------------------------------------------------
// chacha_keystream_xor
// XORs 64-bit data words with a ChaCha keystream set up over an APB port.
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/stall  | in_data_in[63:0], in_restart
//  out     | output    | out_valid/stall | out_data_out[63:0]
//  cfg     | input     | psel/penable    | paddr[5:0], pwdata/prdata[63:0]
//
// A word at block position zero passes through the back end in order: a load
// step, one double round per cycle, a final add, then its serve step. The
// other seven words are served from the stored keystream; no word is served
// while a block is being generated. Results are registered.
// Reset (rst_n, synchronous) clears registers, counter, position and queue.
// A four-entry queue lets input continue while output stalls.
module chacha_keystream_xor import cck_pkg::*; #(
  parameter int ROUNDS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_in,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  regs_t  regs_r;
  logic   q_full, q_empty, q_push, q_pop;
  entry_t q_entry, q_head;
  logic [2:0] reg_idx;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign prdata  = regs_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (psel && penable && pwrite) begin
      regs_r[reg_idx] <= pwdata;
    end
  end

  cck_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data_in (in_data_in),
    .in_restart (in_restart),
    .start_count(regs_r[REG_COUNTER]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  cck_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  cck_back #(.ROUNDS(ROUNDS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (regs_r),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data_out(out_data_out)
  );

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for chacha_keystream_xor: streams data words with
// random restarts and idle bursts, predicts the keystream XOR and compares
// every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cck_pkg::*;

  localparam int Rounds   = 20;
  localparam int WdogMax  = 20000;
  localparam int Drain    = 40;

  typedef struct packed {
    logic [63:0] data;
    logic        restart;
  } word_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_data_in = '0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_data_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  chacha_keystream_xor #(.ROUNDS(Rounds)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state
  logic [63:0] key_regs [NumRegs];
  logic [63:0] blk_ctr;
  logic [2:0]  word_pos;
  logic [31:0] ks_words [16];

  word_item_t  pending_words[$];
  logic [63:0] expected_words[$];
  int          mismatches = 0;
  int          stall_budget = 0;
  int          gap_budget = 0;
  bit          quiet = 1'b0;
  bit          in_taken = 1'b0;
  int          wdog = 0;

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void qr(ref logic [31:0] x[16], input int a, b, c, d);
    x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 16);
    x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 12);
    x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 8);
    x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 7);
  endfunction

  function automatic void build_keystream();
    logic [31:0] init [16];
    logic [31:0] x [16];
    for (int i = 0; i < 6; i++) begin
      init[2*i]   = key_regs[i][31:0];
      init[2*i+1] = key_regs[i][63:32];
    end
    init[12] = blk_ctr[31:0];
    init[13] = blk_ctr[63:32];
    init[14] = key_regs[REG_NONCE][31:0];
    init[15] = key_regs[REG_NONCE][63:32];
    x = init;
    for (int r = 0; r < (Rounds + 1) / 2; r++) begin
      qr(x, 0, 4, 8, 12); qr(x, 1, 5, 9, 13);
      qr(x, 2, 6, 10, 14); qr(x, 3, 7, 11, 15);
      qr(x, 0, 5, 10, 15); qr(x, 1, 6, 11, 12);
      qr(x, 2, 7, 8, 13); qr(x, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = x[i] + init[i];
  endfunction

  // Advance the predictor by one accepted word
  function automatic logic [63:0] xor_keystream(word_item_t w);
    logic [63:0] ks;
    if (w.restart) begin
      blk_ctr  = key_regs[REG_COUNTER];
      word_pos = POS_FIRST;
    end
    if (word_pos == POS_FIRST) build_keystream();
    ks = {ks_words[2*word_pos+1], ks_words[2*word_pos]};
    if (word_pos == POS_LAST) blk_ctr = blk_ctr + 64'd1;
    word_pos = word_pos + 3'd1;
    return w.data ^ ks;
  endfunction

  // Driver: takes items from the pending queue, inserts idle bursts and output stalls
  always @(negedge clk) begin
    if (rst_n) begin
      // a new item goes out only once the current one was taken
      if (!in_valid || in_taken) begin
        if (!quiet && gap_budget == 0 && $urandom_range(0, 9) == 0)
          gap_budget = $urandom_range(1, 7);
        if (gap_budget > 0 || pending_words.size() == 0) begin
          if (gap_budget > 0) gap_budget--;
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          in_data_in <= pending_words[0].data;
          in_restart <= pending_words[0].restart;
          expected_words.push_back(xor_keystream(pending_words.pop_front()));
        end
      end
      if (!quiet && stall_budget == 0 && $urandom_range(0, 9) == 0)
        stall_budget = $urandom_range(1, 7);
      if (stall_budget > 0) begin
        stall_budget--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    in_taken = in_valid && !in_stall;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog = 0;
      else wdog++;
      if (wdog >= WdogMax) begin
        $display("Mismatches found");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("data_out: no result expected, got %h", out_data_out);
          mismatches++;
        end else begin
          logic [63:0] exp_word;
          exp_word = expected_words.pop_front();
          if (out_data_out !== exp_word) begin
            $error("data_out: expected %h, actual %h", exp_word, out_data_out);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    key_regs[idx] = val;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_words.size() != 0 || in_valid)
      @(negedge clk);
    repeat (Drain) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void push_word(logic [63:0] d, logic r);
    word_item_t w;
    w.data = d; w.restart = r;
    pending_words.push_back(w);
  endfunction

  task automatic load_keys(int mode);
    for (int i = 0; i < NumRegs; i++) begin
      logic [63:0] v;
      case (mode)
        0: v = '0;
        1: v = '1;
        default: v = rand64();
      endcase
      write_reg(i[2:0], v);
    end
  endtask

  initial begin
    for (int i = 0; i < NumRegs; i++) key_regs[i] = '0;
    blk_ctr = '0;
    word_pos = POS_FIRST;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all-zero state, extremes of data, restart mid block
    push_word('0, 1'b0);
    push_word('1, 1'b0);
    for (int i = 0; i < 8; i++) push_word(rand64(), 1'b0);
    push_word(64'h5555_5555_5555_5555, 1'b1);
    push_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    wait_idle();

    // All-ones state, counter wraps from max to zero
    load_keys(1);
    for (int i = 0; i < 18; i++) push_word(rand64(), i == 0);
    wait_idle();

    // Key change mid block takes effect at next block; counter write waits
    load_keys(2);
    push_word(rand64(), 1'b1);
    push_word(rand64(), 1'b0);
    wait_idle();
    write_reg(REG_KEY01, rand64());
    write_reg(REG_COUNTER, 64'hFFFF_FFFF_FFFF_FFFE);
    for (int i = 0; i < 20; i++) push_word(rand64(), 1'b0);
    wait_idle();

    // Random phases
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) quiet = 1'b1;
      load_keys(ph == 4 ? 0 : 2);
      if ($urandom_range(0, 1)) write_reg(REG_COUNTER, 64'hFFFF_FFFF_FFFF_FFF0);
      for (int i = 0; i < 330; i++)
        push_word(rand64(), ($urandom_range(0, 39) == 0) || i == 0);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/cck_pkg.sv
src/cck_front.sv
src/cck_queue.sv
src/cck_back.sv
src/chacha_keystream_xor.sv
sim/tb.sv
